[sv/omvci_pkg.sv]
// Shared types, constants and Student-t critical value tables for the
// running mean and confidence interval core. No dependencies.
package omvci_pkg;

	localparam int TableLenDefault = 100;
	localparam int CountWidthDefault = 32;
	localparam int RomLen = 100;
	localparam int RomIdxW = 7;
	localparam logic [63:0] TScale = 64'd100000;
	localparam logic [63:0] TScaleHalf = 64'd50000;
	localparam int ScaleDivW = 17;

	// Confidence level codes.
	typedef enum logic [1:0] {
		CL_95   = 2'd0,
		CL_99   = 2'd1,
		CL_999  = 2'd2,
		CL_9999 = 2'd3
	} conf_level_t;

	typedef struct packed {
		logic signed [31:0] sample;
		logic               first;
	} sample_in_t;

	typedef struct packed {
		logic signed [31:0] mean;
		logic [31:0]        abs_error;
		logic [31:0]        sample_count;
		logic               error_invalid;
	} result_t;

	// Critical values times 100000; entry 0 is never used.
	localparam logic [31:0] T95 [RomLen] = '{ 32'hFFFFFFFF,
		1270620, 430265, 318245, 277645, 257058, 244691, 236462, 230600, 226216, 222814,
		220099, 217881, 216037, 214479, 213145, 211991, 210982, 210092, 209302, 208596,
		207961, 207387, 206866, 206390, 205954, 205553, 205183, 204841, 204523, 204227,
		203951, 203693, 203452, 203224, 203011, 202809, 202619, 202439, 202269, 202108,
		201954, 201808, 201669, 201537, 201410, 201290, 201174, 201063, 200958, 200856,
		200758, 200665, 200575, 200488, 200404, 200324, 200247, 200172, 200100, 200030,
		199962, 199897, 199834, 199773, 199714, 199656, 199601, 199547, 199495, 199444,
		199394, 199346, 199300, 199254, 199210, 199167, 199125, 199085, 199045, 199006,
		198969, 198932, 198896, 198861, 198827, 198793, 198761, 198729, 198698, 198667,
		198638, 198609, 198580, 198552, 198525, 198498, 198472, 198447, 198422 };

	localparam logic [31:0] T99 [RomLen] = '{ 32'hFFFFFFFF,
		6365674, 992484, 584091, 460409, 403214, 370743, 349948, 335539, 324984, 316927,
		310581, 305454, 301228, 297684, 294671, 292078, 289823, 287844, 286093, 284534,
		283136, 281876, 280734, 279694, 278744, 277871, 277068, 276326, 275639, 275000,
		274404, 273848, 273328, 272839, 272381, 271948, 271541, 271156, 270791, 270446,
		270118, 269807, 269510, 269228, 268959, 268701, 268456, 268220, 267995, 267779,
		267572, 267373, 267182, 266998, 266822, 266651, 266487, 266329, 266176, 266028,
		265886, 265748, 265615, 265485, 265360, 265239, 265122, 265008, 264898, 264790,
		264686, 264585, 264487, 264391, 264298, 264208, 264120, 264034, 263950, 263869,
		263790, 263712, 263637, 263563, 263491, 263421, 263353, 263286, 263220, 263157,
		263094, 263033, 262973, 262915, 262858, 262802, 262747, 262693, 262641 };

	localparam logic [31:0] T999 [RomLen] = '{ 32'hFFFFFFFF,
		63661925, 3159905, 1292398, 861030, 686883, 595882, 540788, 504131, 478091, 458689,
		443698, 431779, 422083, 414045, 407277, 401500, 396513, 392165, 388341, 384952,
		381928, 379213, 376763, 374540, 372514, 370661, 368959, 367391, 365941, 364596,
		363346, 362180, 361091, 360072, 359115, 358215, 357367, 356568, 355812, 355097,
		354418, 353775, 353163, 352580, 352025, 351496, 350990, 350507, 350044, 349601,
		349177, 348769, 348378, 348002, 347640, 347292, 346956, 346633, 346321, 346020,
		345729, 345448, 345177, 344914, 344660, 344414, 344175, 343944, 343719, 343501,
		343290, 343085, 342885, 342692, 342503, 342320, 342141, 341968, 341799, 341634,
		341473, 341317, 341164, 341015, 340870, 340728, 340590, 340455, 340323, 340194,
		340067, 339944, 339824, 339706, 339590, 339477, 339367, 339259, 339153 };

	localparam logic [31:0] T9999 [RomLen] = '{ 32'hFFFFFFFF,
		636619767, 9999250, 2800013, 1554410, 1117771, 908235, 788458, 712000, 659368,
		621105, 592119, 569447, 551252, 536341, 523909, 513389, 504376, 496571, 489746,
		483730, 478388, 473612, 469319, 465438, 461914, 458698, 455754, 453047, 450551,
		448242, 446099, 444105, 442246, 440508, 438880, 437351, 435913, 434558, 433279,
		432070, 430925, 429839, 428809, 427829, 426896, 426006, 425158, 424347, 423573,
		422831, 422121, 421439, 420786, 420158, 419554, 418974, 418415, 417876, 417357,
		416857, 416373, 415906, 415455, 415019, 414597, 414188, 413793, 413409, 413038,
		412677, 412327, 411987, 411657, 411337, 411025, 410722, 410428, 410141, 409861,
		409589, 409325, 409066, 408815, 408569, 408330, 408096, 407868, 407645, 407428,
		407216, 407008, 406805, 406607, 406413, 406223, 406038, 405856, 405678, 405504 };

	// Table lookup; indexes past the stored entries read the last one.
	function automatic logic [31:0] t_value(input conf_level_t lvl,
		input logic [RomIdxW-1:0] idx);
		logic [RomIdxW-1:0] i;
		logic [31:0] v;
		i = (idx > RomIdxW'(RomLen - 1)) ? RomIdxW'(RomLen - 1) : idx;
		case (lvl)
			CL_95:   v = T95[i];
			CL_99:   v = T99[i];
			CL_999:  v = T999[i];
			CL_9999: v = T9999[i];
			default: v = T95[i];
		endcase
		return v;
	endfunction

endpackage

[sv/omvci_front.sv]
// Front end: accepts input samples into a two-entry queue for the back end.
// Depends on omvci_pkg.
module omvci_front
	import omvci_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  sample_in_t in_data,
	output logic       q_valid,
	output sample_in_t q_data,
	input  logic       q_pop
);

	sample_in_t mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	assign in_stall = (fill_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign pop      = q_pop && (fill_q != 2'd0);
	assign q_valid  = (fill_q != 2'd0);
	assign q_data   = mem_q[rptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= in_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3) else $error("queue fill level out of range");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == 2'd0 || fill_q == 2'd2) |-> (wptr_q == rptr_q))
		else $error("queue pointers disagree with fill level");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == 2'd0) |=> (fill_q != 2'd2))
		else $error("queue jumped from empty to full");

endmodule

[sv/omvci_div.sv]
// Shared unsigned divider: 64-bit dividend, two quotient bits per cycle.
// Depends on omvci_pkg.
module omvci_div
	import omvci_pkg::*;
#(
	parameter int DivW = ScaleDivW
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [63:0]     dividend,
	input  logic [DivW-1:0] divisor,
	output logic            busy,
	output logic            done,
	output logic [63:0]     quotient
);

	logic [63:0]     quo_q;
	logic [DivW-1:0] rem_q;
	logic [DivW-1:0] dvs_q;
	logic [4:0]      cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [DivW:0]   t1, t2;
	logic            g1, g2;
	logic [DivW-1:0] rem1, rem2;
	logic [63:0]     q1, q2;

	// Two restoring steps.
	always_comb begin
		t1   = {rem_q, quo_q[63]};
		g1   = (t1 >= {1'b0, dvs_q});
		rem1 = g1 ? DivW'(t1 - {1'b0, dvs_q}) : t1[DivW-1:0];
		q1   = {quo_q[62:0], g1};
		t2   = {rem1, q1[63]};
		g2   = (t2 >= {1'b0, dvs_q});
		rem2 = g2 ? DivW'(t2 - {1'b0, dvs_q}) : t2[DivW-1:0];
		q2   = {q1[62:0], g2};
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= q2;
			rem_q <= rem2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without a run");
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider started while busy");

endmodule

[sv/omvci_back.sv]
// Back end: Welford update, error chain (divides, square root, t scaling)
// and the result register. Depends on omvci_pkg and omvci_div.
module omvci_back
	import omvci_pkg::*;
#(
	parameter int CountWidth = CountWidthDefault,
	parameter int TableLen = TableLenDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  conf_level_t level,
	input  logic        q_valid,
	input  sample_in_t  q_data,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output result_t     out_data
);

	localparam int DivW = (CountWidth > ScaleDivW) ? CountWidth : ScaleDivW;
	localparam int LastIdx = ((TableLen < RomLen) ? TableLen : RomLen) - 1;
	localparam logic [CountWidth-1:0] CountMax = '1;
	// Scaled sums at or above this limit give an error past 32 bits.
	localparam logic [63:0] SatLimit = TScale << 32;
	// ceil(2^56 / 3125): the scale by 100000 is a shift by 5 and a divide by 3125.
	localparam logic [47:0] RecipM = 48'd23058430092137;

	typedef enum logic [4:0] {
		S_IDLE, S_DELTA, S_MDIV_GO, S_MDIV_WAIT, S_DELTA2, S_MUL, S_ACC,
		S_EDIV1_GO, S_EDIV1_WAIT, S_EDIV2_GO, S_EDIV2_WAIT, S_SQRT, S_TMUL,
		S_RLOAD, S_RMUL, S_SCALE, S_DONE
	} state_t;

	state_t                 state_q;
	logic [CountWidth-1:0]  count_q;
	logic signed [47:0]     mean_q;
	logic [63:0]            ssd_q;
	logic signed [47:0]     x_q;
	logic [47:0]            mag_q;
	logic [47:0]            mag2_q;
	logic                   neg_q;
	logic [2:0]             mcnt_q;
	logic [47:0]            pp_q;
	logic [95:0]            acc_q;
	logic [63:0]            quo_q;
	logic [63:0]            sx_q;
	logic [63:0]            sr_q;
	logic [63:0]            sbit_q;
	logic [4:0]             scnt_q;
	logic [63:0]            tprod_q;
	logic                   sat_q;
	logic [31:0]            abs_q;
	logic                   inval_q;
	logic                   res_valid_q;
	result_t                res_q;

	logic                   div_start;
	logic [63:0]            div_dividend;
	logic [DivW-1:0]        div_divisor;
	logic                   div_busy;
	logic                   div_done;
	logic [63:0]            div_quo;

	logic signed [48:0]     delta;
	logic signed [48:0]     delta2;
	logic [23:0]            asel;
	logic [23:0]            bsel;
	logic [2:0]             mprev;
	logic [6:0]             mshift;
	logic [64:0]            ssd_sum;
	logic [CountWidth-1:0]  df;
	logic [RomIdxW-1:0]     tidx;
	logic [31:0]            tval;
	logic [63:0]            strial;
	logic [63:0]            rsum;
	logic                   load_out;
	logic [CountWidth-1:0]  cnt_base;

	omvci_div #(.DivW(DivW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Differences from the sample, before and after the mean moves.
	assign delta  = {x_q[47], x_q} - {mean_q[47], mean_q};
	assign delta2 = {x_q[47], x_q} - {mean_q[47], mean_q};

	// Partial product operand selection for the 48 x 48 multiply.
	assign asel   = mcnt_q[1] ? mag_q[47:24] : mag_q[23:0];
	assign bsel   = mcnt_q[0] ? mag2_q[47:24] : mag2_q[23:0];
	assign mprev  = mcnt_q - 3'd1;
	assign mshift = (mprev[1:0] == 2'd0) ? 7'd0 :
		(mprev[1:0] == 2'd3) ? 7'd48 : 7'd24;

	assign ssd_sum = {1'b0, ssd_q} + {1'b0, acc_q[95:32]};

	// Degrees of freedom and table index.
	assign df   = count_q - CountWidth'(1);
	assign tidx = (df > CountWidth'(LastIdx)) ? RomIdxW'(LastIdx) : RomIdxW'(df);
	assign tval = t_value(level, tidx);

	assign strial = sr_q + sbit_q;

	// Rounded t product ahead of the scale by 100000.
	assign rsum = tprod_q + TScaleHalf;

	// Divider operand routing.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = DivW'(count_q);
		case (state_q)
			S_MDIV_GO: begin
				div_start    = 1'b1;
				div_dividend = 64'(mag_q);
			end
			S_EDIV1_GO: begin
				div_start    = 1'b1;
				div_dividend = ssd_q;
			end
			S_EDIV2_GO: begin
				div_start    = 1'b1;
				div_dividend = quo_q;
				div_divisor  = DivW'(df);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign load_out  = (state_q == S_DONE) && (!res_valid_q || !out_stall);
	assign cnt_base  = q_data.first ? '0 : count_q;
	assign out_valid = res_valid_q;
	assign out_data  = res_q;

	// Sequencer with datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			mean_q      <= '0;
			ssd_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !out_stall && !load_out) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						x_q     <= {q_data.sample, 16'h0000};
						count_q <= (cnt_base < CountMax) ? cnt_base + CountWidth'(1)
							: cnt_base;
						if (q_data.first) begin
							mean_q <= '0;
							ssd_q  <= '0;
						end
						state_q <= S_DELTA;
					end
				end
				S_DELTA: begin
					neg_q   <= delta[48];
					mag_q   <= delta[48] ? 48'(-delta) : delta[47:0];
					state_q <= S_MDIV_GO;
				end
				S_MDIV_GO: begin
					state_q <= S_MDIV_WAIT;
				end
				S_MDIV_WAIT: begin
					if (div_done) begin
						mean_q  <= neg_q ? mean_q - $signed(div_quo[47:0])
							: mean_q + $signed(div_quo[47:0]);
						state_q <= S_DELTA2;
					end
				end
				S_DELTA2: begin
					mag2_q  <= delta2[48] ? 48'(-delta2) : delta2[47:0];
					mcnt_q  <= '0;
					acc_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL, S_RMUL: begin
					if (mcnt_q < 3'd4) begin
						pp_q <= asel * bsel;
					end
					if (mcnt_q != 3'd0) begin
						acc_q <= acc_q + (96'(pp_q) << mshift);
					end
					mcnt_q <= mcnt_q + 3'd1;
					if (mcnt_q == 3'd4) begin
						state_q <= (state_q == S_MUL) ? S_ACC : S_SCALE;
					end
				end
				S_ACC: begin
					ssd_q <= ssd_sum[64] ? '1 : ssd_sum[63:0];
					if (count_q < CountWidth'(2)) begin
						abs_q   <= '1;
						inval_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						inval_q <= 1'b0;
						state_q <= S_EDIV1_GO;
					end
				end
				S_EDIV1_GO: begin
					state_q <= S_EDIV1_WAIT;
				end
				S_EDIV1_WAIT: begin
					if (div_done) begin
						quo_q   <= div_quo;
						state_q <= S_EDIV2_GO;
					end
				end
				S_EDIV2_GO: begin
					state_q <= S_EDIV2_WAIT;
				end
				S_EDIV2_WAIT: begin
					if (div_done) begin
						sx_q    <= div_quo;
						sr_q    <= '0;
						sbit_q  <= 64'h4000_0000_0000_0000;
						scnt_q  <= '0;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					// One result bit per cycle.
					if (sx_q >= strial) begin
						sx_q <= sx_q - strial;
						sr_q <= (sr_q >> 1) + sbit_q;
					end else begin
						sr_q <= sr_q >> 1;
					end
					sbit_q <= sbit_q >> 2;
					scnt_q <= scnt_q + 5'd1;
					if (scnt_q == 5'd31) begin
						state_q <= S_TMUL;
					end
				end
				S_TMUL: begin
					tprod_q <= sr_q[31:0] * tval;
					state_q <= S_RLOAD;
				end
				S_RLOAD: begin
					// Below the limit the shifted sum fits in 44 bits.
					sat_q   <= (rsum >= SatLimit);
					mag_q   <= 48'(rsum >> 5);
					mag2_q  <= RecipM;
					mcnt_q  <= '0;
					acc_q   <= '0;
					state_q <= S_RMUL;
				end
				S_SCALE: begin
					abs_q   <= sat_q ? '1 : acc_q[87:56];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						res_q.mean          <= mean_q[47:16];
						res_q.abs_error     <= abs_q;
						res_q.sample_count  <= 32'(count_q);
						res_q.error_invalid <= inval_q;
						res_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (count_q != '0))
		else $error("item in flight with zero count");
	a_invalid_flag: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (res_q.error_invalid == (count_q < CountWidth'(2))))
		else $error("invalid flag does not match count");
	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy) else $error("divider reused while busy");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == S_DELTA)) else $error("pop did not start an item");

endmodule

[sv/online_mean_variance_ci_core.sv]
// Top level of the running mean and Student-t confidence interval core.
// Depends on omvci_pkg, omvci_front and omvci_back.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_stall    sample_in_t (sample, first)
// out       output     out_valid/out_stall  result_t (mean, abs_error,
//                                           sample_count, error_invalid)
// cfg       input      cfg_wr_en            cfg_wr_data (confidence level)
//
// An item in the back end takes three runs of the shared two-bit-per-cycle
// divider with start and handoff (mean step and two error divides), a square
// root, a multiply of the two deltas from four partial products, a reciprocal
// multiply for the t scaling and the control states. Items with fewer than
// two samples skip the error chain. A two-entry input queue and the result
// register let each side stall on its own. Reset is asynchronous and needs no
// clearing pass.
module online_mean_variance_ci_core
	import omvci_pkg::*;
#(
	parameter int COUNT_WIDTH = CountWidthDefault,
	parameter int TABLE_LEN = TableLenDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  sample_in_t in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output result_t    out_data
);

	conf_level_t level_q;
	logic        q_valid;
	sample_in_t  q_data;
	logic        q_pop;

	// Confidence level register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= CL_95;
		end else if (cfg_wr_en) begin
			level_q <= conf_level_t'(cfg_wr_data);
		end
	end

	omvci_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.q_pop    (q_pop)
	);

	omvci_back #(
		.CountWidth (COUNT_WIDTH),
		.TableLen   (TABLE_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.level     (level_q),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
